// File: rtl/core/pct_pkg.sv
// Shared types and codes for the preprocessor conditional tracker.
package pct_pkg;

    localparam int MAX_NESTING_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [1:0] CMD_IF    = 2'd0;
    localparam logic [1:0] CMD_ELIF  = 2'd1;
    localparam logic [1:0] CMD_ELSE  = 2'd2;
    localparam logic [1:0] CMD_ENDIF = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NO_OPEN  = 2'd1;
    localparam logic [1:0] ERR_AFTER_ELSE = 2'd2;
    localparam logic [1:0] ERR_FULL     = 2'd3;

    localparam logic [1:0] SPAN_NONE    = 2'd0;
    localparam logic [1:0] SPAN_REPLACE = 2'd1;
    localparam logic [1:0] SPAN_ERASE   = 2'd2;

    // frame flag bit positions
    localparam int FL_TAKEN = 0;
    localparam int FL_ELSE  = 1;
    localparam int FL_AWAIT = 2;

    typedef logic [2:0] t_flags;

    // classified directive handed from the front to the back
    typedef struct packed {
        logic is_if;
        logic is_alt;    // elif or else
        logic is_else;
        logic is_endif;
        logic cond;      // effective condition, forced high for else
    } t_dir;

endpackage

// File: rtl/core/pct_front.sv
// Front part: classify each directive request and hold it in a two-entry queue.
module pct_front #(
    parameter int OFFSET_BITS = pct_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_cmd,
    input  logic                   i_condition_true,
    input  logic [OFFSET_BITS-1:0] i_directive_start,
    input  logic [OFFSET_BITS-1:0] i_directive_end,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output pct_pkg::t_dir          o_q_dir,
    output logic [OFFSET_BITS-1:0] o_q_start,
    output logic [OFFSET_BITS-1:0] o_q_end
);
    import pct_pkg::*;

    t_dir                   r_dir   [2];
    logic [OFFSET_BITS-1:0] r_start [2];
    logic [OFFSET_BITS-1:0] r_end   [2];
    logic [1:0]             r_cnt, n_cnt;
    logic                   r_wp, r_rp;
    logic                   push;
    t_dir                   dir;

    always_comb begin
        dir = '0;
        unique case (i_cmd)
            CMD_IF: begin
                dir.is_if = 1'b1;
                dir.cond  = i_condition_true;
            end
            CMD_ELIF: begin
                dir.is_alt = 1'b1;
                dir.cond   = i_condition_true;
            end
            CMD_ELSE: begin
                dir.is_alt  = 1'b1;
                dir.is_else = 1'b1;
                dir.cond    = 1'b1;
            end
            default: begin
                dir.is_endif = 1'b1;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_dir    = r_dir[r_rp];
    assign o_q_start  = r_start[r_rp];
    assign o_q_end    = r_end[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !(i_q_pop && o_q_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop && o_q_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop && o_q_valid) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_dir[r_wp]   <= dir;
            r_start[r_wp] <= i_directive_start;
            r_end[r_wp]   <= i_directive_end;
        end
    end

endmodule

// File: rtl/core/pct_back.sv
// Back part: conditional stack, ignore tracking and the registered result stage.
module pct_back #(
    parameter int MAX_NESTING = pct_pkg::MAX_NESTING_DEF,
    parameter int OFFSET_BITS = pct_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  pct_pkg::t_dir          i_q_dir,
    input  logic [OFFSET_BITS-1:0] i_q_start,
    input  logic [OFFSET_BITS-1:0] i_q_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_must_skip,
    output logic [1:0]             o_error_code,
    output logic [1:0]             o_span_kind,
    output logic [OFFSET_BITS-1:0] o_region_start,
    output logic [OFFSET_BITS-1:0] o_region_end,
    output logic [OFFSET_BITS-1:0] o_kept_start,
    output logic [OFFSET_BITS-1:0] o_kept_end
);
    import pct_pkg::*;

    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    // frames below the top of the stack
    t_flags                 mem_flags [MAX_NESTING];
    logic [OFFSET_BITS-1:0] mem_rs    [MAX_NESTING];
    logic [OFFSET_BITS-1:0] mem_ks    [MAX_NESTING];
    logic [OFFSET_BITS-1:0] mem_ke    [MAX_NESTING];

    t_flags                 r_rd_flags;
    logic [OFFSET_BITS-1:0] r_rd_rs, r_rd_ks, r_rd_ke;

    t_flags                 r_top_flags, n_top_flags, top_flags;
    logic [OFFSET_BITS-1:0] r_top_rs, n_top_rs, top_rs;
    logic [OFFSET_BITS-1:0] r_top_ks, n_top_ks, top_ks;
    logic [OFFSET_BITS-1:0] r_top_ke, n_top_ke, top_ke;
    logic                   r_top_in_mem, n_top_in_mem;

    logic [DW-1:0]          r_depth, n_depth;
    logic                   r_ign_act, n_ign_act;
    logic [DW-1:0]          r_ign_lvl, n_ign_lvl;

    logic                   fire, push_wr, ign_now, ign_push;
    logic [IW-1:0]          wr_idx, rd_idx;

    logic                   skip;
    logic [1:0]             err, kind;
    logic [OFFSET_BITS-1:0] rs, re, ks, ke;
    logic                   was, cond_alt;

    logic                   r_out_valid;
    logic                   r_skip;
    logic [1:0]             r_err, r_kind;
    logic [OFFSET_BITS-1:0] r_rs, r_re, r_ks, r_ke;

    assign fire    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = fire;

    // top frame comes from the read port just after a pop
    assign top_flags = r_top_in_mem ? r_rd_flags : r_top_flags;
    assign top_rs    = r_top_in_mem ? r_rd_rs    : r_top_rs;
    assign top_ks    = r_top_in_mem ? r_rd_ks    : r_top_ks;
    assign top_ke    = r_top_in_mem ? r_rd_ke    : r_top_ke;

    assign ign_now  = r_ign_act && (r_depth > r_ign_lvl);
    assign ign_push = r_ign_act && ((r_depth + DW'(1)) > r_ign_lvl);
    assign wr_idx   = IW'(r_depth - DW'(1));
    assign rd_idx   = (n_depth == '0) ? '0 : IW'(n_depth - DW'(1));

    always_comb begin
        n_top_flags  = r_top_flags;
        n_top_rs     = r_top_rs;
        n_top_ks     = r_top_ks;
        n_top_ke     = r_top_ke;
        n_top_in_mem = r_top_in_mem;
        n_depth      = r_depth;
        n_ign_act    = r_ign_act;
        n_ign_lvl    = r_ign_lvl;
        push_wr      = 1'b0;
        skip         = 1'b0;
        err          = ERR_OK;
        kind         = SPAN_NONE;
        rs           = '0;
        re           = '0;
        ks           = '0;
        ke           = '0;
        was          = top_flags[FL_TAKEN];
        cond_alt     = i_q_dir.cond;

        if (fire) begin
            if (i_q_dir.is_if) begin
                if (r_depth >= DW'(MAX_NESTING)) begin
                    err = ERR_FULL;
                end else begin
                    // push the old top down, open a fresh frame
                    push_wr      = (r_depth != '0);
                    n_top_flags  = '0;
                    n_top_flags[FL_TAKEN] = i_q_dir.cond;
                    n_top_flags[FL_AWAIT] = i_q_dir.cond;
                    n_top_rs     = i_q_start;
                    n_top_ks     = i_q_dir.cond ? i_q_end : '0;
                    n_top_ke     = '0;
                    n_top_in_mem = 1'b0;
                    n_depth      = r_depth + DW'(1);
                    if (ign_push) begin
                        skip = 1'b1;
                    end else if (!i_q_dir.cond) begin
                        skip      = 1'b1;
                        n_ign_act = 1'b1;
                        n_ign_lvl = r_depth + DW'(1);
                    end else begin
                        n_ign_act = 1'b0;
                        n_ign_lvl = '0;
                    end
                end
            end else if (r_depth == '0) begin
                err = ERR_NO_OPEN;
            end else if (i_q_dir.is_alt) begin
                if (top_flags[FL_ELSE]) begin
                    err = ERR_AFTER_ELSE;
                end else begin
                    n_top_flags  = top_flags;
                    n_top_rs     = top_rs;
                    n_top_ks     = top_ks;
                    n_top_ke     = top_ke;
                    n_top_in_mem = 1'b0;
                    if (i_q_dir.is_else) begin
                        n_top_flags[FL_ELSE] = 1'b1;
                    end
                    if (was) begin
                        if (top_flags[FL_AWAIT]) begin
                            n_top_ke              = i_q_start;
                            n_top_flags[FL_AWAIT] = 1'b0;
                        end
                    end else if (cond_alt) begin
                        n_top_flags[FL_TAKEN] = 1'b1;
                        n_top_flags[FL_AWAIT] = 1'b1;
                        n_top_ks              = i_q_end;
                    end
                    if (ign_now) begin
                        skip = 1'b1;
                    end else if (was || !cond_alt) begin
                        skip      = 1'b1;
                        n_ign_act = 1'b1;
                        n_ign_lvl = r_depth;
                    end else begin
                        n_ign_act = 1'b0;
                        n_ign_lvl = '0;
                    end
                end
            end else begin
                // endif: close the frame, report the region when live
                if (!ign_now) begin
                    rs = top_rs;
                    re = i_q_end;
                    if (top_flags[FL_TAKEN]) begin
                        kind = SPAN_REPLACE;
                        ks   = top_ks;
                        ke   = top_flags[FL_AWAIT] ? i_q_start : top_ke;
                    end else begin
                        kind = SPAN_ERASE;
                    end
                end else begin
                    skip = 1'b1;
                end
                n_depth      = r_depth - DW'(1);
                n_top_in_mem = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_wr) begin
            mem_flags[wr_idx] <= top_flags;
            mem_rs[wr_idx]    <= top_rs;
            mem_ks[wr_idx]    <= top_ks;
            mem_ke[wr_idx]    <= top_ke;
        end
        r_rd_flags <= mem_flags[rd_idx];
        r_rd_rs    <= mem_rs[rd_idx];
        r_rd_ks    <= mem_ks[rd_idx];
        r_rd_ke    <= mem_ke[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        r_top_flags <= n_top_flags;
        r_top_rs    <= n_top_rs;
        r_top_ks    <= n_top_ks;
        r_top_ke    <= n_top_ke;
        if (fire) begin
            r_skip <= skip;
            r_err  <= err;
            r_kind <= kind;
            r_rs   <= rs;
            r_re   <= re;
            r_ks   <= ks;
            r_ke   <= ke;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_ign_act    <= 1'b0;
            r_ign_lvl    <= '0;
            r_top_in_mem <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_depth      <= n_depth;
            r_ign_act    <= n_ign_act;
            r_ign_lvl    <= n_ign_lvl;
            r_top_in_mem <= n_top_in_mem;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_must_skip    = r_skip;
    assign o_error_code   = r_err;
    assign o_span_kind    = r_kind;
    assign o_region_start = r_rs;
    assign o_region_end   = r_re;
    assign o_kept_start   = r_ks;
    assign o_kept_end     = r_ke;

endmodule

// File: rtl/core/preprocessor_conditional_tracker.sv
// Top level of the preprocessor conditional tracker: front queue plus stack back end.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | cmd, condition_true, directive offsets
//  out     | output    | o_out_valid/i_out_stall | skip, error, span kind, region, kept span
//
//  One request per cycle sustained while the output is not stalled. A taken request waits in the
//  front queue until the back end works on it, and its result is held in the registered output stage.
//  The stack top lives in registers and lower frames in a memory whose registered read port
//  is addressed with the next depth, so after a pop the new top is ready for the next request.
//  Reset clears the queue, depth, ignore state and output valid; frames need no clearing pass.
//  A stalled output holds its result while the two-entry queue takes requests until full.
module preprocessor_conditional_tracker #(
    parameter int MAX_NESTING = pct_pkg::MAX_NESTING_DEF,
    parameter int OFFSET_BITS = pct_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_cmd,
    input  logic                   i_condition_true,
    input  logic [OFFSET_BITS-1:0] i_directive_start,
    input  logic [OFFSET_BITS-1:0] i_directive_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_must_skip,
    output logic [1:0]             o_error_code,
    output logic [1:0]             o_span_kind,
    output logic [OFFSET_BITS-1:0] o_region_start,
    output logic [OFFSET_BITS-1:0] o_region_end,
    output logic [OFFSET_BITS-1:0] o_kept_start,
    output logic [OFFSET_BITS-1:0] o_kept_end
);
    import pct_pkg::*;

    // queue to back end
    logic                   q_valid;
    logic                   q_pop;
    t_dir                   q_dir;
    logic [OFFSET_BITS-1:0] q_start;
    logic [OFFSET_BITS-1:0] q_end;

    // classify and hold requests
    pct_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_condition_true  (i_condition_true),
        .i_directive_start (i_directive_start),
        .i_directive_end   (i_directive_end),
        .o_q_valid         (q_valid),
        .i_q_pop           (q_pop),
        .o_q_dir           (q_dir),
        .o_q_start         (q_start),
        .o_q_end           (q_end)
    );

    // advance the conditional stack and register the result
    pct_back #(
        .MAX_NESTING (MAX_NESTING),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_dir        (q_dir),
        .i_q_start      (q_start),
        .i_q_end        (q_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_must_skip    (o_must_skip),
        .o_error_code   (o_error_code),
        .o_span_kind    (o_span_kind),
        .o_region_start (o_region_start),
        .o_region_end   (o_region_end),
        .o_kept_start   (o_kept_start),
        .o_kept_end     (o_kept_end)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the preprocessor conditional tracker.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam int OFS         = OFFSET_BITS_DEF;
    localparam int DEPTH_MAX   = MAX_NESTING_DEF;
    localparam int N_RANDOM    = 1850;
    localparam int QUIET_TAIL  = 200;
    localparam int CYCLE_LIMIT = 400000;

    // One queued request for the sender. A drain entry carries no directive:
    // it holds the sender back until every outstanding result has arrived.
    typedef struct packed {
        logic           drain;
        logic [4:0]     gap;
        logic [1:0]     cmd;
        logic           cond;
        logic [OFS-1:0] ds;
        logic [OFS-1:0] de;
    } t_dir_req;

    typedef struct packed {
        logic           skip;
        logic [1:0]     err;
        logic [1:0]     kind;
        logic [OFS-1:0] rs;
        logic [OFS-1:0] re;
        logic [OFS-1:0] ks;
        logic [OFS-1:0] ke;
    } t_dir_result;

    // DUT ports, all inputs known from time zero
    logic           i_clk             = 1'b0;
    logic           i_rst_n           = 1'b0;
    logic           i_in_valid        = 1'b0;
    logic           o_in_stall;
    logic [1:0]     i_cmd             = CMD_IF;
    logic           i_condition_true  = 1'b0;
    logic [OFS-1:0] i_directive_start = '0;
    logic [OFS-1:0] i_directive_end   = '0;
    logic           o_out_valid;
    logic           i_out_stall       = 1'b0;
    logic           o_must_skip;
    logic [1:0]     o_error_code;
    logic [1:0]     o_span_kind;
    logic [OFS-1:0] o_region_start;
    logic [OFS-1:0] o_region_end;
    logic [OFS-1:0] o_kept_start;
    logic [OFS-1:0] o_kept_end;

    preprocessor_conditional_tracker #(
        .MAX_NESTING(DEPTH_MAX),
        .OFFSET_BITS(OFS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_condition_true (i_condition_true),
        .i_directive_start(i_directive_start),
        .i_directive_end  (i_directive_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_must_skip      (o_must_skip),
        .o_error_code     (o_error_code),
        .o_span_kind      (o_span_kind),
        .o_region_start   (o_region_start),
        .o_region_end     (o_region_end),
        .o_kept_start     (o_kept_start),
        .o_kept_end       (o_kept_end)
    );

    // ------------------------------------------------------------------
    // Shadow of the conditional stack, advanced once per accepted request
    // ------------------------------------------------------------------
    t_flags         stk_flags    [DEPTH_MAX];
    logic [OFS-1:0] stk_region   [DEPTH_MAX];
    logic [OFS-1:0] stk_kstart   [DEPTH_MAX];
    logic [OFS-1:0] stk_kend     [DEPTH_MAX];
    int             stk_depth    = 0;
    bit             ign_active   = 1'b0;
    int             ign_level    = 0;

    t_dir_result    directive_outcomes_q[$];
    t_dir_req       directive_q[$];

    // bookkeeping
    int             err_count      = 0;
    int             results_seen   = 0;
    int             requests_taken = 0;
    int             total_requests = 0;
    int             cycles         = 0;
    int             drains_done    = 0;
    int             deepest        = 0;
    int             skips_seen     = 0;
    int             err_seen  [4];
    int             span_seen [3];

    // generator shadow: only depth and else-seen per level, enough to shape
    // well-formed sequences
    int             gen_depth = 0;
    bit             gen_else [DEPTH_MAX+1];
    logic [OFS-1:0] text_cursor = '0;

    // handshake and sender state
    logic           in_fire    = 1'b0;
    bit             holding    = 1'b0;
    bit             have_next  = 1'b0;
    int             gap_left   = 0;
    t_dir_req       nxt;
    int             stall_left = 0;

    function automatic bit in_ignored_scope();
        return ign_active && (stk_depth > ign_level);
    endfunction

    // Advance the shadow stack by one directive and return its result.
    function automatic t_dir_result step_conditional_stack(
        input logic [1:0] cmd, input logic cond_in,
        input logic [OFS-1:0] ds, input logic [OFS-1:0] de
    );
        t_dir_result r;
        int          t;
        logic        cond;
        logic        was;
        r    = '0;
        cond = cond_in;
        if (cmd == CMD_IF) begin
            if (stk_depth >= DEPTH_MAX) begin
                r.err = ERR_FULL;
            end else begin
                t = stk_depth;
                stk_flags[t]  = '0;
                stk_flags[t][FL_TAKEN] = cond;
                stk_flags[t][FL_AWAIT] = cond;
                stk_region[t] = ds;
                stk_kstart[t] = cond ? de : '0;
                stk_kend[t]   = '0;
                stk_depth++;
                if (in_ignored_scope()) begin
                    r.skip = 1'b1;
                end else if (!cond) begin
                    r.skip     = 1'b1;
                    ign_active = 1'b1;
                    ign_level  = stk_depth;
                end else begin
                    ign_active = 1'b0;
                    ign_level  = 0;
                end
            end
        end else if (stk_depth == 0) begin
            r.err = ERR_NO_OPEN;
        end else if (cmd == CMD_ELIF || cmd == CMD_ELSE) begin
            t = stk_depth - 1;
            if (stk_flags[t][FL_ELSE]) begin
                r.err = ERR_AFTER_ELSE;
            end else begin
                // else acts as an elif whose condition holds
                if (cmd == CMD_ELSE) begin
                    cond = 1'b1;
                    stk_flags[t][FL_ELSE] = 1'b1;
                end
                was = stk_flags[t][FL_TAKEN];
                if (was) begin
                    if (stk_flags[t][FL_AWAIT]) begin
                        stk_kend[t] = ds;
                        stk_flags[t][FL_AWAIT] = 1'b0;
                    end
                end else if (cond) begin
                    stk_flags[t][FL_TAKEN] = 1'b1;
                    stk_flags[t][FL_AWAIT] = 1'b1;
                    stk_kstart[t] = de;
                end
                if (in_ignored_scope()) begin
                    r.skip = 1'b1;
                end else if (was || !cond) begin
                    r.skip     = 1'b1;
                    ign_active = 1'b1;
                    ign_level  = stk_depth;
                end else begin
                    ign_active = 1'b0;
                    ign_level  = 0;
                end
            end
        end else begin
            t = stk_depth - 1;
            if (!in_ignored_scope()) begin
                if (stk_flags[t][FL_TAKEN] && stk_flags[t][FL_AWAIT]) begin
                    stk_kend[t] = ds;
                    stk_flags[t][FL_AWAIT] = 1'b0;
                end
                r.rs = stk_region[t];
                r.re = de;
                if (stk_flags[t][FL_TAKEN]) begin
                    r.kind = SPAN_REPLACE;
                    r.ks   = stk_kstart[t];
                    r.ke   = stk_kend[t];
                end else begin
                    r.kind = SPAN_ERASE;
                end
            end else begin
                r.skip = 1'b1;
            end
            stk_depth--;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OFS-1:0] got,
                                   input logic [OFS-1:0] want);
        err_count++;
        $display("MISMATCH result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
    endtask

    // Queue one directive and keep the generator shadow in step with it.
    task automatic queue_directive(input logic [1:0] cmd, input logic cond,
                                   input logic [OFS-1:0] ds, input logic [OFS-1:0] de,
                                   input int gap);
        t_dir_req q;
        q.drain = 1'b0;
        q.gap   = gap[4:0];
        q.cmd   = cmd;
        q.cond  = cond;
        q.ds    = ds;
        q.de    = de;
        directive_q.push_back(q);
        total_requests++;
        case (cmd)
            CMD_IF: begin
                if (gen_depth < DEPTH_MAX) begin
                    gen_else[gen_depth] = 1'b0;
                    gen_depth++;
                end
            end
            CMD_ELSE: begin
                if (gen_depth > 0) gen_else[gen_depth-1] = 1'b1;
            end
            CMD_ENDIF: begin
                if (gen_depth > 0) gen_depth--;
            end
            default: ;
        endcase
    endtask

    task automatic queue_drain();
        t_dir_req q;
        q       = '0;
        q.drain = 1'b1;
        directive_q.push_back(q);
    endtask

    // Pick the next random directive: mostly well-formed, some noise.
    task automatic queue_random_directive(input int push_pct, input bit gaps_on,
                                          input bit quiet);
        logic [1:0]     cmd;
        logic [OFS-1:0] ds;
        logic [OFS-1:0] de;
        int             r;
        int             gap;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            cmd = 2'($urandom_range(0, 3));
        end else if (gen_depth == 0) begin
            cmd = CMD_IF;
        end else if (gen_depth >= DEPTH_MAX) begin
            r   = $urandom_range(0, 99);
            cmd = (r < 25) ? CMD_IF : (r < 40 && !gen_else[gen_depth-1]) ? CMD_ELIF
                                                                          : CMD_ENDIF;
        end else if ($urandom_range(0, 99) < push_pct) begin
            cmd = CMD_IF;
        end else if (gen_else[gen_depth-1]) begin
            cmd = CMD_ENDIF;
        end else begin
            r   = $urandom_range(0, 99);
            cmd = (r < 30) ? CMD_ELIF : (r < 50) ? CMD_ELSE : CMD_ENDIF;
        end
        // half the offsets walk forward through a text, half are arbitrary
        if ($urandom_range(0, 1)) begin
            text_cursor = text_cursor + $urandom_range(0, 200);
            ds          = text_cursor;
            text_cursor = text_cursor + $urandom_range(1, 80);
            de          = text_cursor;
        end else begin
            ds = $urandom;
            de = $urandom;
        end
        gap = 0;
        if (gaps_on && !quiet && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 18);
        queue_directive(cmd, 1'($urandom_range(0, 1)), ds, de, gap);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Cycle limit: abandon a hung run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, directive_outcomes_q.size());
            $display("preprocessor_conditional_tracker test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: present requests at the falling edge, hold each until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // drop the request that was taken at the last rising edge
            if (holding && in_fire) holding = 1'b0;
            if (!holding) begin
                if (!have_next && directive_q.size() > 0) begin
                    nxt       = directive_q.pop_front();
                    have_next = 1'b1;
                    gap_left  = int'(nxt.gap);
                end
                if (have_next) begin
                    if (nxt.drain) begin
                        // hold off until every expected result has come back
                        if (directive_outcomes_q.size() == 0) begin
                            have_next = 1'b0;
                            drains_done++;
                        end
                    end else if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        holding            = 1'b1;
                        have_next          = 1'b0;
                        i_cmd             <= nxt.cmd;
                        i_condition_true  <= nxt.cond;
                        i_directive_start <= nxt.ds;
                        i_directive_end   <= nxt.de;
                    end
                end
            end
            i_in_valid <= holding;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in bursts, none once the run reaches its tail and
    // none in every third stretch of results
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit stalls_on;
        stalls_on = (results_seen < total_requests - QUIET_TAIL) &&
                    (((results_seen / 150) % 3) != 2);
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && stalls_on && $urandom_range(0, 99) < 8) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every taken request, then check every taken
    // result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dir_result got;
        t_dir_result want;
        if (i_rst_n) begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                want = step_conditional_stack(i_cmd, i_condition_true,
                                              i_directive_start, i_directive_end);
                directive_outcomes_q.push_back(want);
                requests_taken++;
                err_seen[want.err]++;
                if (want.err == ERR_OK) span_seen[want.kind]++;
                if (want.skip) skips_seen++;
                if (stk_depth > deepest) deepest = stk_depth;
            end
            if (o_out_valid && !i_out_stall) begin
                got.skip = o_must_skip;
                got.err  = o_error_code;
                got.kind = o_span_kind;
                got.rs   = o_region_start;
                got.re   = o_region_end;
                got.ks   = o_kept_start;
                got.ke   = o_kept_end;
                if (directive_outcomes_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, '0);
                end else begin
                    want = directive_outcomes_q.pop_front();
                    if (got.skip !== want.skip)
                        report_mismatch("must_skip", OFS'(got.skip), OFS'(want.skip));
                    if (got.err !== want.err)
                        report_mismatch("error_code", OFS'(got.err), OFS'(want.err));
                    if (got.kind !== want.kind)
                        report_mismatch("span_kind", OFS'(got.kind), OFS'(want.kind));
                    if (got.rs !== want.rs)     report_mismatch("region_start", got.rs, want.rs);
                    if (got.re !== want.re)     report_mismatch("region_end", got.re, want.re);
                    if (got.ks !== want.ks)     report_mismatch("kept_start", got.ks, want.ks);
                    if (got.ke !== want.ke)     report_mismatch("kept_end", got.ke, want.ke);
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int push_pct;
        bit gaps_on;
        foreach (err_seen[k]) err_seen[k] = 0;
        foreach (span_seen[k]) span_seen[k] = 0;
        push_pct = 45;
        gaps_on  = 1'b1;

        // closing directives with nothing open
        queue_directive(CMD_ENDIF, 1'b0, 32'h0000_0010, 32'h0000_0018, 0);
        queue_directive(CMD_ELIF,  1'b1, 32'h0000_0020, 32'h0000_0028, 0);
        queue_directive(CMD_ELSE,  1'b0, 32'h0000_0030, 32'h0000_0038, 2);

        // live conditional taken at the if, with offsets at both extremes;
        // a second else and a late elif must both be refused
        queue_directive(CMD_IF,    1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 0);
        queue_directive(CMD_ELIF,  1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        queue_directive(CMD_ELSE,  1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        queue_directive(CMD_ELSE,  1'b1, 32'h0000_0100, 32'h0000_0108, 0);
        queue_directive(CMD_ELIF,  1'b0, 32'h0000_0110, 32'h0000_0118, 0);
        queue_directive(CMD_ENDIF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);

        // branch chosen at a later elif, nested live if inside it, then else
        queue_directive(CMD_IF,    1'b0, 32'h0000_1000, 32'h0000_1010, 0);
        queue_directive(CMD_ELIF,  1'b0, 32'h0000_1020, 32'h0000_1030, 0);
        queue_directive(CMD_ELIF,  1'b1, 32'h0000_1040, 32'h0000_1050, 0);
        queue_directive(CMD_IF,    1'b1, 32'h0000_1060, 32'h0000_1070, 0);
        queue_directive(CMD_ENDIF, 1'b1, 32'h0000_1080, 32'h0000_1090, 0);
        queue_directive(CMD_ELSE,  1'b0, 32'h0000_10A0, 32'h0000_10B0, 0);
        queue_directive(CMD_ENDIF, 1'b0, 32'h0000_10C0, 32'h0000_10D0, 1);

        // no branch taken: inner directives sit in an ignored scope, and the
        // outer endif erases the whole region
        queue_directive(CMD_IF,    1'b0, 32'h0000_2000, 32'h0000_2010, 0);
        queue_directive(CMD_IF,    1'b1, 32'h0000_2020, 32'h0000_2030, 0);
        queue_directive(CMD_ELIF,  1'b0, 32'h0000_2040, 32'h0000_2050, 0);
        queue_directive(CMD_ENDIF, 1'b0, 32'h0000_2060, 32'h0000_2070, 0);
        queue_directive(CMD_ENDIF, 1'b1, 32'h0000_2080, 32'h0000_2090, 0);

        // let the directed part settle completely before the random part
        queue_drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            // vary push bias and sender idling in stretches; a heavy push bias
            // drives the stack to full and past it
            if (i % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 45;
                    default: push_pct = 70;
                endcase
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (i == N_RANDOM / 2) queue_drain();
            queue_random_directive(push_pct, gaps_on, i >= N_RANDOM - QUIET_TAIL);
        end

        // hold reset, then release it at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // advance until the sender has nothing left, then until all results are in
        while (directive_q.size() != 0 || have_next || holding) @(posedge i_clk);
        while (directive_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests; errors no-open/after-else/full: %0d/%0d/%0d",
                 requests_taken, err_seen[ERR_NO_OPEN], err_seen[ERR_AFTER_ELSE],
                 err_seen[ERR_FULL]);
        $display("spans none/replace/erase: %0d/%0d/%0d, skips %0d, deepest %0d, drains %0d",
                 span_seen[SPAN_NONE], span_seen[SPAN_REPLACE], span_seen[SPAN_ERASE],
                 skips_seen, deepest, drains_done);
        if (err_count == 0) begin
            $display("preprocessor_conditional_tracker test passed");
        end else begin
            $display("preprocessor_conditional_tracker test failed");
        end
        $finish;
    end

endmodule
